FILE: design/kvt_pkg.sv
// Shared types, constants and helpers for the key/value command-line tokenizer.
// No dependencies; every other design file refers to this package by scoped name.

package kvt_pkg;

	localparam int MAX_ITEMS   = 256;
	localparam int STORE_BYTES = 8192;

	localparam int ITEM_W  = $clog2(MAX_ITEMS + 1);
	localparam int STORE_W = $clog2(STORE_BYTES + 1);
	localparam int NUM_W   = 9;
	localparam int SLOTS   = 3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_VALUE = 2'd1,
		KIND_END   = 2'd2,
		KIND_DONE  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       final_byte;
	} cmd_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       out_byte;
		logic             has_key;
		logic             has_value;
		logic [NUM_W-1:0] item_number;
		logic             items_dropped;
		logic             run_last;
	} tok_t;

	typedef struct packed {
		logic [SLOTS-1:0] valid;
		tok_t [SLOTS-1:0] slot;
	} slots_t;

	// Map the item counter onto the fixed-width item number field.
	function automatic logic [NUM_W-1:0] num_out(input logic [ITEM_W-1:0] count);
		logic [ITEM_W+NUM_W-1:0] wide;
		wide = (ITEM_W + NUM_W)'(count);
		return wide[NUM_W-1:0];
	endfunction

	function automatic logic is_term(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) ||
			(c == CH_HASH);
	endfunction

endpackage

FILE: design/kvt_if.sv
// Valid/ready channel interfaces for command bytes and token results.
// Depends on kvt_pkg for the payload types.

interface kvt_cmd_if;
	logic          valid;
	logic          ready;
	kvt_pkg::cmd_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface kvt_tok_if;
	logic          valid;
	logic          ready;
	kvt_pkg::tok_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

FILE: design/kvt_input_stage.sv
// Input register for command bytes.
// Depends on kvt_pkg and kvt_cmd_if.

module kvt_input_stage (
	input  logic           clk,
	input  logic           arst_n,
	kvt_cmd_if.sink        cmd,
	input  logic           take,
	output logic           valid_s1,
	output kvt_pkg::cmd_t  cmd_s1
);

	logic accept;

	assign cmd.ready = !valid_s1 || take;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd.data;
		end
	end

endmodule

FILE: design/kvt_core.sv
// Tokenizer state and the single-pass decision logic for one byte.
// Produces up to three result slots (byte, item end, done). Depends on kvt_pkg.

module kvt_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  kvt_pkg::cmd_t    cmd_s1,
	output kvt_pkg::slots_t  slots
);

	logic                        side_q, inq_q, tn_q, kp_q, vp_q, ovf_q;
	logic [7:0]                  qc_q;
	logic [kvt_pkg::ITEM_W-1:0]  cnt_q;
	logic [kvt_pkg::STORE_W-1:0] used_q;

	logic                        side_d, inq_d, tn_d, kp_d, vp_d, ovf_d;
	logic [7:0]                  qc_d;
	logic [kvt_pkg::ITEM_W-1:0]  cnt_d;
	logic [kvt_pkg::STORE_W-1:0] used_d;

	always_comb begin
		logic [7:0] c;
		logic       last, keep, bump, end_req;
		c       = cmd_s1.char_byte;
		last    = cmd_s1.final_byte;
		keep    = 1'b0;
		bump    = 1'b0;
		end_req = 1'b0;
		side_d  = side_q;
		inq_d   = inq_q;
		qc_d    = qc_q;
		tn_d    = tn_q;
		kp_d    = kp_q;
		vp_d    = vp_q;
		ovf_d   = ovf_q;
		cnt_d   = cnt_q;
		used_d  = used_q;
		slots   = '0;

		if (inq_q) begin
			if (c == qc_q) begin
				inq_d = 1'b0;
			end else if (used_q >= kvt_pkg::STORE_W'(kvt_pkg::STORE_BYTES - 1)) begin
				inq_d = 1'b0;
			end else begin
				keep = 1'b1;
			end
		end else if (c == kvt_pkg::CH_DQ || c == kvt_pkg::CH_SQ) begin
			inq_d = 1'b1;
			qc_d  = c;
		end else if (kvt_pkg::is_term(c)) begin
			// close the open token, then the item
			if (tn_q) begin
				if (side_q) begin
					kp_d = 1'b1;
				end else begin
					vp_d = 1'b1;
				end
				bump = 1'b1;
				tn_d = 1'b0;
			end
			end_req = 1'b1;
			side_d  = 1'b1;
		end else if (c == kvt_pkg::CH_EQ && side_q) begin
			side_d = 1'b0;
			kp_d   = 1'b1;
			bump   = 1'b1;
			tn_d   = 1'b0;
		end else if (used_q < kvt_pkg::STORE_W'(kvt_pkg::STORE_BYTES)) begin
			keep = 1'b1;
		end

		if (keep) begin
			tn_d                     = 1'b1;
			bump                     = 1'b1;
			slots.valid[0]           = 1'b1;
			slots.slot[0].kind       = side_q ? kvt_pkg::KIND_KEY : kvt_pkg::KIND_VALUE;
			slots.slot[0].out_byte   = c;
		end

		if (bump && used_q < kvt_pkg::STORE_W'(kvt_pkg::STORE_BYTES)) begin
			used_d = used_q + kvt_pkg::STORE_W'(1);
		end

		// the last byte flushes an open token without a separator
		if (last) begin
			if (tn_d) begin
				if (side_d) begin
					kp_d = 1'b1;
				end else begin
					vp_d = 1'b1;
				end
			end
			end_req = 1'b1;
		end

		if (end_req) begin
			if (kp_d || vp_d) begin
				if (cnt_q < kvt_pkg::ITEM_W'(kvt_pkg::MAX_ITEMS)) begin
					slots.valid[1]            = 1'b1;
					slots.slot[1].kind        = kvt_pkg::KIND_END;
					slots.slot[1].has_key     = kp_d;
					slots.slot[1].has_value   = vp_d;
					slots.slot[1].item_number = kvt_pkg::num_out(cnt_q);
					cnt_d = cnt_q + kvt_pkg::ITEM_W'(1);
				end else begin
					ovf_d = 1'b1;
				end
			end
			kp_d = 1'b0;
			vp_d = 1'b0;
		end

		if (last) begin
			slots.valid[2]              = 1'b1;
			slots.slot[2].kind          = kvt_pkg::KIND_DONE;
			slots.slot[2].item_number   = kvt_pkg::num_out(cnt_d);
			slots.slot[2].items_dropped = ovf_d;
			// start the next command line from the reset state
			side_d = 1'b1;
			inq_d  = 1'b0;
			qc_d   = '0;
			tn_d   = 1'b0;
			kp_d   = 1'b0;
			vp_d   = 1'b0;
			ovf_d  = 1'b0;
			cnt_d  = '0;
			used_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 1'b1;
			inq_q  <= 1'b0;
			qc_q   <= '0;
			tn_q   <= 1'b0;
			kp_q   <= 1'b0;
			vp_q   <= 1'b0;
			ovf_q  <= 1'b0;
			cnt_q  <= '0;
			used_q <= '0;
		end else if (go) begin
			side_q <= side_d;
			inq_q  <= inq_d;
			qc_q   <= qc_d;
			tn_q   <= tn_d;
			kp_q   <= kp_d;
			vp_q   <= vp_d;
			ovf_q  <= ovf_d;
			cnt_q  <= cnt_d;
			used_q <= used_d;
		end
	end

endmodule

FILE: design/kvt_result_stage.sv
// Result register: holds the slots of one byte and hands them out in order.
// Depends on kvt_pkg and kvt_tok_if.

module kvt_result_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  kvt_pkg::slots_t  slots,
	output logic             can_load,
	kvt_tok_if.source        tok
);

	logic [kvt_pkg::SLOTS-1:0] valid_s2;
	kvt_pkg::tok_t [kvt_pkg::SLOTS-1:0] slot_s2;
	logic [kvt_pkg::SLOTS-1:0] pick, rest;
	logic                      pop;

	always_comb begin
		pick = '0;
		if (valid_s2[0]) begin
			pick[0] = 1'b1;
		end else if (valid_s2[1]) begin
			pick[1] = 1'b1;
		end else if (valid_s2[2]) begin
			pick[2] = 1'b1;
		end
		rest = valid_s2 & ~pick;
	end

	always_comb begin
		tok.data = '0;
		for (int i = 0; i < kvt_pkg::SLOTS; i++) begin
			if (pick[i]) begin
				tok.data = slot_s2[i];
			end
		end
		tok.data.run_last = (rest == '0);
	end

	assign tok.valid = |valid_s2;
	assign pop       = tok.valid && tok.ready;
	assign can_load  = (valid_s2 == '0) || (pop && rest == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= '0;
		end else if (load) begin
			valid_s2 <= slots.valid;
		end else if (pop) begin
			valid_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_s2 <= slots.slot;
		end
	end

endmodule

FILE: design/key_value_cmdline_tokenizer_top.sv
// A byte accepted into the input register passes through the core logic into the result
// register once its earlier results are all taken; its first result then drives tok.
// Throughput: one byte per cycle while tok takes every result; a byte with several results
// holds the output until all are taken, and the input register takes the next byte meanwhile.
// Reset (arst_n low): tokenizer state returns to the key side with no quote, no item,
// zero item count and an empty store count; both pipeline stages are emptied.
// Depends on kvt_pkg, kvt_if and the kvt_* stage modules.

module key_value_cmdline_tokenizer_top (
	input  logic       clk,
	input  logic       arst_n,
	kvt_cmd_if.sink    cmd,
	kvt_tok_if.source  tok
);

	logic             valid_s1, can_load, go;
	kvt_pkg::cmd_t    cmd_s1;
	kvt_pkg::slots_t  slots;

	assign go = valid_s1 && can_load;

	kvt_input_stage u_input (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.take     (go),
		.valid_s1 (valid_s1),
		.cmd_s1   (cmd_s1)
	);

	kvt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.cmd_s1 (cmd_s1),
		.slots  (slots)
	);

	kvt_result_stage u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (go),
		.slots    (slots),
		.can_load (can_load),
		.tok      (tok)
	);

endmodule

FILE: verif/key_value_cmdline_tokenizer_top_tb.sv
// Self-checking testbench for key_value_cmdline_tokenizer_top: drives command bytes,
// predicts the token stream and checks every result as it leaves the block.
// Depends on kvt_pkg, the kvt_cmd_if/kvt_tok_if interfaces and the design top.

module key_value_cmdline_tokenizer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import kvt_pkg::*;

	logic clk;
	logic arst_n;

	kvt_cmd_if cmd();
	kvt_tok_if tok();

	key_value_cmdline_tokenizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd.sink),
		.tok    (tok.source)
	);

	// Tokenizer state as the predictor sees it
	logic        key_side;
	logic        quoting;
	logic [7:0]  quote_byte;
	logic        token_open;
	logic        seen_key;
	logic        seen_value;
	int unsigned items_seen;
	int unsigned bytes_stored;
	logic        items_lost;

	tok_t step_results[$];
	tok_t expected_tokens[$];

	int unsigned gap_pct;
	int unsigned stall_pct;
	int unsigned bytes_sent;
	int unsigned mismatch_count;
	int unsigned results_checked;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(30_000_000);
		$display("RESULT: ERROR");
		$finish;
	end

	task automatic flag_mismatch(input string msg);
		$display("mismatch at result %0d: %s", results_checked, msg);
		mismatch_count++;
	endtask

	function automatic int unsigned pick_gap(input int unsigned pct);
		if ($urandom_range(99) >= pct)
			return 0;
		if ($urandom_range(9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic ends_item(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_HASH);
	endfunction

	function automatic logic [7:0] rand_plain();
		logic [7:0] c;
		do
			c = 8'($urandom_range(1, 255));
		while (ends_item(c) || c == CH_EQ || c == CH_DQ || c == CH_SQ);
		return c;
	endfunction

	function automatic void reset_tokenizer();
		key_side     = 1'b1;
		quoting      = 1'b0;
		quote_byte   = 8'h00;
		token_open   = 1'b0;
		seen_key     = 1'b0;
		seen_value   = 1'b0;
		items_seen   = 0;
		bytes_stored = 0;
		items_lost   = 1'b0;
	endfunction

	function automatic void add_result(input kind_t k, input logic [7:0] b, input logic hk,
			input logic hv, input int unsigned num, input logic drop);
		tok_t t;
		t.kind          = k;
		t.out_byte      = b;
		t.has_key       = hk;
		t.has_value     = hv;
		t.item_number   = num[NUM_W-1:0];
		t.items_dropped = drop;
		t.run_last      = 1'b0;
		step_results.push_back(t);
	endfunction

	function automatic void bump_store();
		if (bytes_stored < STORE_BYTES)
			bytes_stored++;
	endfunction

	function automatic void keep_byte(input logic [7:0] c);
		if (key_side)
			add_result(KIND_KEY, c, 1'b0, 1'b0, 0, 1'b0);
		else
			add_result(KIND_VALUE, c, 1'b0, 1'b0, 0, 1'b0);
		bump_store();
		token_open = 1'b1;
	endfunction

	// Items past the limit are counted as lost, not numbered
	function automatic void close_item();
		if (seen_key || seen_value) begin
			if (items_seen < MAX_ITEMS) begin
				add_result(KIND_END, 8'h00, seen_key, seen_value, items_seen, 1'b0);
				items_seen++;
			end else begin
				items_lost = 1'b1;
			end
		end
		seen_key   = 1'b0;
		seen_value = 1'b0;
	endfunction

	function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
		step_results.delete();
		if (quoting) begin
			// a nearly full store also ends the quote
			if (c == quote_byte || bytes_stored >= STORE_BYTES - 1)
				quoting = 1'b0;
			else
				keep_byte(c);
		end else if (c == CH_DQ || c == CH_SQ) begin
			quoting    = 1'b1;
			quote_byte = c;
		end else if (ends_item(c)) begin
			if (token_open) begin
				if (key_side)
					seen_key = 1'b1;
				else
					seen_value = 1'b1;
				bump_store();
				token_open = 1'b0;
			end
			close_item();
			key_side = 1'b1;
		end else if (c == CH_EQ && key_side) begin
			key_side   = 1'b0;
			seen_key   = 1'b1;
			token_open = 1'b0;
			bump_store();
		end else if (bytes_stored < STORE_BYTES) begin
			keep_byte(c);
		end

		if (fin) begin
			if (token_open) begin
				if (key_side)
					seen_key = 1'b1;
				else
					seen_value = 1'b1;
			end
			close_item();
			add_result(KIND_DONE, 8'h00, 1'b0, 1'b0, items_seen, items_lost);
			reset_tokenizer();
		end

		if (step_results.size() > 0)
			step_results[step_results.size() - 1].run_last = 1'b1;
		foreach (step_results[i])
			expected_tokens.push_back(step_results[i]);
	endfunction

	task automatic send_byte(input logic [7:0] c, input logic fin);
		cmd_t req;
		int unsigned gap;
		gap = pick_gap(gap_pct);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.char_byte  = c;
		req.final_byte = fin;
		cmd.data  <= req;
		cmd.valid <= 1'b1;
		@(posedge clk);
		while (!cmd.ready)
			@(posedge clk);
		tokenize_byte(c, fin);
		bytes_sent++;
	endtask

	task automatic send_text(input string s, input logic last);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last && (i == s.len() - 1));
	endtask

	// Hold the sender until every predicted result is out, then let stragglers surface
	task automatic drain_results();
		cmd.valid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	function automatic void append_word(ref logic [7:0] line[$]);
		int unsigned len;
		logic [7:0] q;
		logic [7:0] c;
		len = $urandom_range(0, 5);
		repeat (len) begin
			if ($urandom_range(99) < 80) begin
				line.push_back(rand_plain());
			end else begin
				q = ($urandom_range(1) == 0) ? CH_DQ : CH_SQ;
				line.push_back(q);
				repeat ($urandom_range(0, 4)) begin
					do
						c = 8'($urandom_range(1, 255));
					while (c == q);
					line.push_back(c);
				end
				if ($urandom_range(99) < 85)
					line.push_back(q);
			end
		end
	endfunction

	task automatic send_random_line();
		logic [7:0] line[$];
		logic [7:0] enders[5];
		enders = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_HASH};
		repeat ($urandom_range(1, 6)) begin
			if ($urandom_range(99) < 12) begin
				repeat ($urandom_range(1, 4))
					line.push_back(8'($urandom_range(1, 255)));
			end else begin
				append_word(line);
				if ($urandom_range(99) < 70) begin
					line.push_back(CH_EQ);
					append_word(line);
					if ($urandom_range(99) < 15) begin
						line.push_back(CH_EQ);
						append_word(line);
					end
				end
			end
			repeat ($urandom_range(1, 2))
				line.push_back(enders[$urandom_range(4)]);
		end
		foreach (line[i])
			send_byte(line[i], i == line.size() - 1);
	endtask

	task automatic test_directed_items();
		gap_pct   = 0;
		stall_pct = 0;
		send_text("k=v=", 1'b0);
		send_byte(CH_TAB, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(CH_EQ, 1'b0);
		send_byte(CH_LF, 1'b0);
		send_text("=x", 1'b0);
		send_byte(CH_CR, 1'b0);
		send_text("k=#", 1'b0);
		send_text("'a b'=\"c'\"", 1'b0);
		send_byte(CH_SPACE, 1'b0);
		send_text("'u", 1'b1);
		drain_results();
	endtask

	task automatic test_single_byte_lines();
		gap_pct   = 30;
		stall_pct = 30;
		send_byte(CH_SPACE, 1'b1);
		send_byte(CH_EQ, 1'b1);
		send_byte(CH_SQ, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(CH_HASH, 1'b1);
		drain_results();
	endtask

	task automatic test_item_limit();
		gap_pct   = 10;
		stall_pct = 20;
		for (int i = 0; i < MAX_ITEMS + 2; i++) begin
			send_byte(rand_plain(), 1'b0);
			send_byte(($urandom_range(1) == 0) ? CH_SPACE : CH_HASH, 1'b0);
		end
		send_byte(rand_plain(), 1'b1);
		// the next line must start with a clean count
		send_text("a=b", 1'b1);
		drain_results();
	endtask

	task automatic test_store_full();
		logic [7:0] c;
		gap_pct   = 0;
		stall_pct = 0;
		send_byte(CH_DQ, 1'b0);
		repeat (STORE_BYTES + 2) begin
			do
				c = 8'($urandom_range(1, 255));
			while (c == CH_DQ);
			send_byte(c, 1'b0);
		end
		send_text("bb=cc dd", 1'b0);
		send_byte(rand_plain(), 1'b1);
		drain_results();
	endtask

	task automatic test_random_lines();
		int unsigned start;
		logic paused;
		int unsigned levels[3];
		levels = '{0, 20, 60};
		start  = bytes_sent;
		paused = 1'b0;
		while (bytes_sent - start < 480) begin
			gap_pct   = levels[$urandom_range(2)];
			stall_pct = levels[$urandom_range(2)];
			send_random_line();
			if (!paused && bytes_sent - start >= 240) begin
				drain_results();
				paused = 1'b1;
			end
		end
		drain_results();
	endtask

	// Result side: check at each accepted edge, then pick the next ready level
	initial begin
		tok_t got;
		tok_t want;
		int unsigned stall_left;
		stall_left = 0;
		tok.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && tok.valid && tok.ready) begin
				got = tok.data;
				if (expected_tokens.size() == 0) begin
					flag_mismatch($sformatf("result with no request pending, kind %0d",
						got.kind));
				end else begin
					want = expected_tokens.pop_front();
					if (got.kind !== want.kind)
						flag_mismatch($sformatf("kind got %0d want %0d", got.kind, want.kind));
					if (got.out_byte !== want.out_byte)
						flag_mismatch($sformatf("out_byte got %h want %h",
							got.out_byte, want.out_byte));
					if (got.has_key !== want.has_key)
						flag_mismatch($sformatf("has_key got %b want %b",
							got.has_key, want.has_key));
					if (got.has_value !== want.has_value)
						flag_mismatch($sformatf("has_value got %b want %b",
							got.has_value, want.has_value));
					if (got.item_number !== want.item_number)
						flag_mismatch($sformatf("item_number got %0d want %0d",
							got.item_number, want.item_number));
					if (got.items_dropped !== want.items_dropped)
						flag_mismatch($sformatf("items_dropped got %b want %b",
							got.items_dropped, want.items_dropped));
					if (got.run_last !== want.run_last)
						flag_mismatch($sformatf("run_last got %b want %b",
							got.run_last, want.run_last));
				end
				results_checked++;
			end
			if (stall_left == 0)
				stall_left = pick_gap(stall_pct);
			if (stall_left > 0) begin
				tok.ready <= 1'b0;
				stall_left--;
			end else begin
				tok.ready <= 1'b1;
			end
		end
	end

	initial begin
		arst_n    <= 1'b0;
		cmd.valid <= 1'b0;
		cmd.data  <= '0;
		gap_pct         = 0;
		stall_pct       = 0;
		bytes_sent      = 0;
		mismatch_count  = 0;
		results_checked = 0;
		reset_tokenizer();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_items();
		test_single_byte_lines();
		test_item_limit();
		test_store_full();
		test_random_lines();

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
